/* sv/gbc_pkg.sv */
`default_nettype none

package gbc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int AXES      = 3;
    localparam int LIMIT_W   = 16;
    localparam int PROG_W    = 10;
    localparam int RESTART_W = 32;

    // Rounded bias magnitude never exceeds 32768, so sixteen quotient bits suffice.
    localparam int Q_W       = 16;
    // Bias update: reciprocal multiply, then apply the sign.
    localparam int DIV_STEPS = 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;  // 32767
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;  // -32768

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_SPREAD_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET      = 16'd200;

    // Per-item control fanned out from the controller to every lane.
    typedef struct packed {
        logic accept;
        logic active;
        logic first;
        logic discard;
        logic complete;
        logic div_step;
        logic div_last;
    } gbc_lane_ctl_t;

    // Result status held by the controller.
    typedef struct packed {
        logic                 calibrated;
        logic                 completed_now;
        logic [PROG_W-1:0]    window_progress;
        logic [RESTART_W-1:0] restart_total;
    } gbc_status_t;

endpackage

`default_nettype wire

/* sv/gbc_if.sv */
`default_nettype none

interface gbc_in_if
    import gbc_pkg::*;
    ;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    output ready);
endinterface

interface gbc_out_if
    import gbc_pkg::*;
    ;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] corrected_x;
    logic signed [SAMPLE_W-1:0] corrected_y;
    logic signed [SAMPLE_W-1:0] corrected_z;
    logic                       calibrated;
    logic                       completed_now;
    logic [PROG_W-1:0]          window_progress;
    logic [RESTART_W-1:0]       restart_total;
    logic signed [SAMPLE_W-1:0] bias_out_x;
    logic signed [SAMPLE_W-1:0] bias_out_y;
    logic signed [SAMPLE_W-1:0] bias_out_z;

    modport source (output valid, output corrected_x, output corrected_y,
                    output corrected_z, output calibrated, output completed_now,
                    output window_progress, output restart_total,
                    output bias_out_x, output bias_out_y, output bias_out_z,
                    input ready);
    modport sink   (input valid, input corrected_x, input corrected_y,
                    input corrected_z, input calibrated, input completed_now,
                    input window_progress, input restart_total,
                    input bias_out_x, input bias_out_y, input bias_out_z,
                    output ready);
endinterface

`default_nettype wire

/* sv/gyro_bias_still_window_calibrator.sv */
// Channel      Direction  Transfer condition         Payload
// sample_ch    in         valid && ready             sample_x/y/z
// result_ch    out        valid && ready             corrected_x/y/z, calibrated,
//                                                    completed_now, window_progress,
//                                                    restart_total, bias_out_x/y/z
// APB          cfg        psel && penable && pwrite  spread_limit at byte address 0
//
// One sample per cycle while the divider is idle and no stalled result blocks input;
// one result per sample, held in the result register. The sample that completes
// calibration holds the input side while each lane multiplies the rounded sum by a
// reciprocal of WINDOW, then applies the sign; its result surfaces once the new
// bias is stored. Reset is asynchronous active low; spread_limit comes up at 200,
// all bias, sum, count and restart state at zero. No clearing pass is needed.
// A stalled result holds; a new sample is taken in the cycle its result slot frees.
`default_nettype none

module gyro_bias_still_window_calibrator
    import gbc_pkg::*;
#(
    parameter int WINDOW = 1000
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    gbc_in_if.sink                     sample_ch,
    gbc_out_if.source                  result_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [LIMIT_W-1:0]         limit_reg;
    logic                       limit_hit;

    gbc_lane_ctl_t              lane_ctl;
    gbc_status_t                status;
    logic [AXES-1:0]            moved;
    logic signed [SAMPLE_W-1:0] sample_arr    [AXES];
    logic signed [SAMPLE_W-1:0] corrected_arr [AXES];
    logic signed [SAMPLE_W-1:0] bias_arr      [AXES];

    // Configuration: single register, decode on the word index.
    assign pready    = 1'b1;
    assign limit_hit = paddr[APB_ADDR_W-1:2] == REG_SPREAD_LIMIT;
    assign prdata    = limit_hit ? {{(APB_DATA_W - LIMIT_W){1'b0}}, limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && limit_hit)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign sample_arr[0] = sample_ch.sample_x;
    assign sample_arr[1] = sample_ch.sample_y;
    assign sample_arr[2] = sample_ch.sample_z;

    // One lane per axis: extremes, sum, divider and correction run side by side.
    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        gbc_lane #(
            .WINDOW (WINDOW)
        ) u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (lane_ctl),
            .sample       (sample_arr[a]),
            .spread_limit (limit_reg),
            .moved        (moved[a]),
            .corrected    (corrected_arr[a]),
            .bias         (bias_arr[a])
        );
    end

    // Merge: OR the lane stillness verdicts, advance count, restarts and divider.
    gbc_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .out_ready (result_ch.ready),
        .moved     (moved),
        .in_ready  (sample_ch.ready),
        .out_valid (result_ch.valid),
        .ctl       (lane_ctl),
        .status    (status)
    );

    assign result_ch.corrected_x     = corrected_arr[0];
    assign result_ch.corrected_y     = corrected_arr[1];
    assign result_ch.corrected_z     = corrected_arr[2];
    assign result_ch.bias_out_x      = bias_arr[0];
    assign result_ch.bias_out_y      = bias_arr[1];
    assign result_ch.bias_out_z      = bias_arr[2];
    assign result_ch.calibrated      = status.calibrated;
    assign result_ch.completed_now   = status.completed_now;
    assign result_ch.window_progress = status.window_progress;
    assign result_ch.restart_total   = status.restart_total;

endmodule

`default_nettype wire

/* sv/gbc_lane.sv */
`default_nettype none

module gbc_lane
    import gbc_pkg::*;
#(
    parameter int WINDOW = 1000
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire gbc_lane_ctl_t              ctl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic [LIMIT_W-1:0]         spread_limit,
    output logic                            moved,
    output logic signed [SAMPLE_W-1:0]      corrected,
    output logic signed [SAMPLE_W-1:0]      bias
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = CNT_W + SAMPLE_W;
    localparam logic [SUM_W-1:0] HALF = SUM_W'(WINDOW / 2);

    // Rounded-up reciprocal of WINDOW, exact for every dividend below 2^SUM_W.
    localparam int     QUO_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int     RCP_W     = SUM_W + 1;
    localparam int     PROD_W    = SUM_W + RCP_W;
    localparam longint RCP_WIDE  = ((longint'(1) << QUO_SHIFT) + longint'(WINDOW) - 1)
                                   / longint'(WINDOW);
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_WIDE);

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SAMPLE_W-1:0] low_reg;
    logic signed [SAMPLE_W-1:0] high_reg;
    logic signed [SAMPLE_W-1:0] bias_reg;
    logic [SUM_W-1:0]           rem_reg;
    logic [Q_W-1:0]             quo_reg;
    logic                       neg_reg;

    logic signed [SAMPLE_W-1:0] low_next;
    logic signed [SAMPLE_W-1:0] high_next;
    logic signed [SAMPLE_W:0]   spread;
    logic signed [SUM_W-1:0]    sum_add;
    logic [SUM_W-1:0]           sum_mag;
    logic [SUM_W-1:0]           dividend;
    logic [PROD_W-1:0]          product;
    logic [Q_W-1:0]             quo_next;
    logic signed [SAMPLE_W-1:0] bias_next;
    logic signed [SAMPLE_W:0]   diff;

    // Window extremes; the first sample of a window reseeds both.
    assign low_next  = (ctl.first || (sample < low_reg))  ? sample : low_reg;
    assign high_next = (ctl.first || (sample > high_reg)) ? sample : high_reg;
    assign spread    = {high_next[SAMPLE_W-1], high_next} - {low_next[SAMPLE_W-1], low_next};
    assign moved     = spread[LIMIT_W-1:0] > spread_limit;

    assign sum_add  = sum_reg + {{(SUM_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    assign sum_mag  = sum_add[SUM_W-1] ? (~sum_add + 1'b1) : sum_add;
    assign dividend = sum_mag + HALF;

    // Divide by WINDOW: multiply by the reciprocal, then restore the sign.
    assign product   = {{RCP_W{1'b0}}, rem_reg} * {{SUM_W{1'b0}}, RECIP};
    assign quo_next  = product[QUO_SHIFT +: Q_W];
    assign bias_next = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    // Saturate sample minus bias to 16-bit signed.
    assign diff = {sample_reg[SAMPLE_W-1], sample_reg} - {bias_reg[SAMPLE_W-1], bias_reg};
    always_comb
    begin
        if (diff[SAMPLE_W] != diff[SAMPLE_W-1])
        begin
            corrected = diff[SAMPLE_W] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            corrected = diff[SAMPLE_W-1:0];
        end
    end

    assign bias = bias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            low_reg  <= '0;
            high_reg <= '0;
            bias_reg <= '0;
        end
        else
        begin
            if (ctl.accept && ctl.active)
            begin
                low_reg  <= low_next;
                high_reg <= high_next;
                sum_reg  <= ctl.discard ? '0 : sum_add;
            end
            if (ctl.div_last)
            begin
                bias_reg <= bias_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            sample_reg <= sample;
        end
        if (ctl.complete)
        begin
            rem_reg <= dividend;
            neg_reg <= sum_add[SUM_W-1];
        end
        else if (ctl.div_step && !ctl.div_last)
        begin
            quo_reg <= quo_next;
        end
    end

endmodule

`default_nettype wire

/* sv/gbc_ctrl.sv */
`default_nettype none

module gbc_ctrl
    import gbc_pkg::*;
#(
    parameter int WINDOW = 1000
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            out_ready,
    input  wire logic [AXES-1:0] moved,
    output logic                 in_ready,
    output logic                 out_valid,
    output gbc_lane_ctl_t        ctl,
    output gbc_status_t          status
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);

    logic [CNT_W-1:0]     count_reg;
    logic [RESTART_W-1:0] restart_reg;
    logic                 done_reg;
    logic                 busy_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 out_valid_reg;
    logic                 completed_reg;

    logic                    accept;
    logic                    update;
    logic                    discard;
    logic                    complete;
    logic                    div_last;
    logic [CNT_W-1:0]        count_inc;
    logic [CNT_W+PROG_W-1:0] count_ext;

    assign in_ready  = !busy_reg && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign update    = accept && !done_reg;
    assign discard   = update && (|moved);
    assign count_inc = count_reg + 1'b1;
    assign complete  = update && !discard && (count_inc == WIN_CNT);
    assign div_last  = busy_reg && (step_reg == STEP_LAST);

    always_comb
    begin
        ctl.accept   = accept;
        ctl.active   = !done_reg;
        ctl.first    = count_reg == '0;
        ctl.discard  = discard;
        ctl.complete = complete;
        ctl.div_step = busy_reg;
        ctl.div_last = div_last;
    end

    assign count_ext = {{PROG_W{1'b0}}, count_reg};

    always_comb
    begin
        status.calibrated      = done_reg;
        status.completed_now   = completed_reg;
        status.window_progress = count_ext[PROG_W-1:0];
        status.restart_total   = restart_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            restart_reg   <= '0;
            done_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            completed_reg <= 1'b0;
        end
        else
        begin
            if (discard)
            begin
                count_reg   <= '0;
                restart_reg <= restart_reg + 1'b1;
            end
            else if (update)
            begin
                count_reg <= count_inc;
            end

            if (accept)
            begin
                completed_reg <= complete;
            end

            if (complete)
            begin
                done_reg <= 1'b1;
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (div_last)
                begin
                    busy_reg <= 1'b0;
                end
            end

            // Completing item surfaces only once the divider has finished.
            priority if (accept && !complete)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (div_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= out_valid_reg;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/gbc_checker.sv */
`default_nettype none

module gbc_checker
    import gbc_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic                       calibrated,
    input wire logic                       completed_now,
    input wire logic signed [SAMPLE_W-1:0] corrected_x,
    input wire logic signed [SAMPLE_W-1:0] bias_out_x,
    input wire logic signed [SAMPLE_W-1:0] bias_out_y,
    input wire logic signed [SAMPLE_W-1:0] bias_out_z
);

    // Hold a stalled result: valid stays up and corrected_x stays stable.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(corrected_x))
        else $error("result changed or dropped while stalled");

    a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && completed_now |-> calibrated)
        else $error("completion reported without calibrated flag");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        calibrated |=> calibrated)
        else $error("calibrated flag dropped");

    a_bias_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !calibrated |->
            bias_out_x == '0 && bias_out_y == '0 && bias_out_z == '0)
        else $error("bias nonzero before calibration");

endmodule

bind gyro_bias_still_window_calibrator gbc_checker u_gbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .calibrated    (result_ch.calibrated),
    .completed_now (result_ch.completed_now),
    .corrected_x   (result_ch.corrected_x),
    .bias_out_x    (result_ch.bias_out_x),
    .bias_out_y    (result_ch.bias_out_y),
    .bias_out_z    (result_ch.bias_out_z)
);

`default_nettype wire
